/* rtl/sfe_pkg.sv */
// Package for the spectrum frame encoder: frame constants, byte slot codes
// and the type of one queued bin transaction. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

  localparam int unsigned BINS_DEFAULT = 128;
  localparam int unsigned MAG_W        = 32;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
  localparam logic [15:0]       MAG_MAX     = 16'hFFFF;

  // Byte slots of one bin transaction, in emission order.
  typedef enum logic [2:0] {
    SLOT_SYNC_A  = 3'd0,
    SLOT_SYNC_B  = 3'd1,
    SLOT_LEN_LO  = 3'd2,
    SLOT_LEN_HI  = 3'd3,
    SLOT_MAG_LO  = 3'd4,
    SLOT_MAG_HI  = 3'd5,
    SLOT_CHKSUM  = 3'd6
  } slot_t;

  typedef struct packed {
    logic [BYTE_W-1:0] mag_lo;
    logic [BYTE_W-1:0] mag_hi;
    logic [BYTE_W-1:0] chksum;
    slot_t             final_slot;
    logic              single;
  } item_t;

endpackage

`default_nettype wire

/* rtl/spectrum_frame_encoder_top.sv */
// Spectrum frame encoder top level: saturates bin magnitudes and serializes
// them into sync/length/payload/checksum byte frames. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  input   | in_valid / in_ready  | magnitude[31:0] signed
//  output  | out_valid / out_ready| frame_byte[7:0], frame_end
//
//  One output byte per cycle unless stalled; a bin gives two bytes mid-frame,
//  six first and three last (six if BINS is 1). The output byte register sets
//  the pace. A new bin is taken in the cycle the previous bin's last byte
//  moves to the output register. Synchronous reset clears frame position,
//  checksum and both valid flags. Output stalls back up through in_ready.
module spectrum_frame_encoder_top #(
  parameter int unsigned BINS = sfe_pkg::BINS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [sfe_pkg::MAG_W-1:0]   magnitude,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [sfe_pkg::BYTE_W-1:0]  frame_byte,
  output logic                             frame_end
);

  import sfe_pkg::*;

  localparam int unsigned POS_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BINS - 1);
  localparam logic [15:0] FRAME_LEN = 16'(2 * BINS);

  logic [POS_W-1:0]  bin_position, bin_position_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;

  item_t             item, item_next;
  logic              item_valid;
  slot_t             slot, slot_next;

  logic [15:0]       mag_sat;
  logic              is_first, is_last;
  logic              accept, out_load, item_done;
  logic [BYTE_W-1:0] slot_byte;
  logic              slot_end;

  // Saturate to 0..65535
  always_comb begin
    if (magnitude[MAG_W-1]) begin
      mag_sat = '0;
    end else if (|magnitude[MAG_W-2:16]) begin
      mag_sat = MAG_MAX;
    end else begin
      mag_sat = magnitude[15:0];
    end
  end

  assign is_first = (bin_position == '0);
  assign is_last  = (bin_position >= LAST_POS);

  always_comb begin
    running_xor_next     = (is_first ? '0 : running_xor) ^ mag_sat[7:0] ^ mag_sat[15:8];
    item_next.mag_lo     = mag_sat[7:0];
    item_next.mag_hi     = mag_sat[15:8];
    item_next.chksum     = running_xor_next;
    item_next.single     = is_first && is_last;
    item_next.final_slot = (is_last && !is_first) ? SLOT_CHKSUM : SLOT_MAG_HI;
    slot_next            = is_first ? SLOT_SYNC_A : SLOT_MAG_LO;
    bin_position_next    = is_last ? '0 : bin_position + POS_W'(1);
  end

  always_comb begin
    slot_end = 1'b0;
    unique case (slot)
      SLOT_SYNC_A: slot_byte = SYNC_FIRST;
      SLOT_SYNC_B: slot_byte = SYNC_SECOND;
      SLOT_LEN_LO: slot_byte = FRAME_LEN[7:0];
      SLOT_LEN_HI: slot_byte = FRAME_LEN[15:8];
      SLOT_MAG_LO: slot_byte = item.mag_lo;
      SLOT_MAG_HI: begin
        slot_byte = item.mag_hi;
        slot_end  = item.single;
      end
      SLOT_CHKSUM: begin
        slot_byte = item.chksum;
        slot_end  = 1'b1;
      end
      default:     slot_byte = '0;
    endcase
  end

  assign out_load  = item_valid && (!out_valid || out_ready);
  assign item_done = out_load && (slot == item.final_slot);
  assign in_ready  = !item_valid || item_done;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position <= '0;
      running_xor  <= '0;
      item_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        bin_position <= bin_position_next;
        running_xor  <= is_last ? '0 : running_xor_next;
        item_valid   <= 1'b1;
      end else if (item_done) begin
        item_valid   <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
      slot <= slot_next;
    end else if (out_load) begin
      slot <= slot_t'(slot + 3'd1);
    end
    if (out_load) begin
      frame_byte <= slot_byte;
      frame_end  <= slot_end;
    end
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for spectrum_frame_encoder_top: random and directed bin magnitudes,
// a local frame predictor and a byte-by-byte checker. Depends on sfe_pkg.
`timescale 1ns / 1ps

module tb;
  import sfe_pkg::*;

  localparam int unsigned BINS      = BINS_DEFAULT;
  localparam int unsigned CYCLE_CAP = 600000;
  localparam int unsigned MAX_SHOWN = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MAG_W-1:0]  magnitude = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_end;

  // frame position and payload XOR as the block should hold them
  logic [14:0]       next_bin = '0;
  logic [BYTE_W-1:0] payload_xor = '0;
  frame_byte_t       pending_bytes[$];

  int unsigned       cycles = 0;
  int unsigned       errors = 0;
  bit                idle_in = 1'b0;
  bit                stall_out = 1'b0;
  int unsigned       stall_left = 0;

  spectrum_frame_encoder_top #(.BINS(BINS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .magnitude  (magnitude),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
    frame_byte_t fb;
    fb.data = data;
    fb.last = last;
    pending_bytes.push_back(fb);
  endtask

  // Bytes one accepted bin produces: header on the first bin of a frame,
  // two payload bytes, and the checksum after the last bin unless BINS is 1.
  task automatic encode_bin(input logic [MAG_W-1:0] raw);
    logic [15:0]       sat;
    logic [15:0]       len;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    bit                closing;
    if (raw[31])
      sat = '0;
    else if (raw[30:16] != '0)
      sat = MAG_MAX;
    else
      sat = raw[15:0];
    lo = sat[7:0];
    hi = sat[15:8];
    len = 16'(BINS * 2);
    closing = (int'(next_bin) >= int'(BINS) - 1);
    if (next_bin == '0) begin
      payload_xor = '0;
      push_byte(SYNC_FIRST, 1'b0);
      push_byte(SYNC_SECOND, 1'b0);
      push_byte(len[7:0], 1'b0);
      push_byte(len[15:8], 1'b0);
    end
    payload_xor = payload_xor ^ lo ^ hi;
    if (closing && next_bin == '0) begin
      // one-bin frame: no room for a checksum, the high byte ends the frame
      push_byte(lo, 1'b0);
      push_byte(hi, 1'b1);
    end else begin
      push_byte(lo, 1'b0);
      push_byte(hi, 1'b0);
      if (closing)
        push_byte(payload_xor, 1'b1);
    end
    if (closing) begin
      next_bin = '0;
      payload_xor = '0;
    end else begin
      next_bin = next_bin + 15'd1;
    end
  endtask

  // Predict on each input transaction, compare each output transaction.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        encode_bin(magnitude);
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end %0b", frame_byte, frame_end));
        end else begin
          want = pending_bytes.pop_front();
          if (frame_byte !== want.data)
            report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte, want.data));
          if (frame_end !== want.last)
            report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin : ready_gen
    int unsigned g;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap(stall_out);
      if (g != 0) begin
        out_ready <= 1'b0;
        stall_left <= g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Valid stays up between back-to-back bins; it only drops for a gap.
  task automatic send_bin(input logic [MAG_W-1:0] value);
    int unsigned gap;
    gap = pick_gap(idle_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    magnitude <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [MAG_W-1:0] pick_magnitude();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: begin
        return $urandom_range(0, 65535);
      end
      5: begin
        return $urandom() | 32'h8000_0000;
      end
      6: begin
        return 32'd65534 + $urandom_range(0, 3);
      end
      7: begin
        return $urandom();
      end
      8: begin
        return $urandom_range(65536, 32'h7FFF_FFFF);
      end
      default: begin
        return $urandom_range(0, 3) << (8 * $urandom_range(0, 1));
      end
    endcase
  endfunction

  // Saturation edges and the extremes of the signed input range.
  task automatic test_saturation_edges();
    logic [MAG_W-1:0] edges[$];
    edges = {32'h0000_0000, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0100,
             32'h0000_FF00, 32'h0000_FFFE, 32'h0000_FFFF, 32'h0001_0000,
             32'h0001_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
             32'hFFFF_0000, 32'h5555_AAAA, 32'h0000_A55A, 32'h0000_5AA5};
    idle_in   = 1'b0;
    stall_out = 1'b0;
    foreach (edges[i])
      send_bin(edges[i]);
  endtask

  // Full-scale and negative bins at random, with both sides idling, so a header and payload get split.
  task automatic test_edges_with_stalls();
    idle_in   = 1'b1;
    stall_out = 1'b1;
    repeat (8)
      send_bin($urandom_range(0, 1) ? 32'h0000_FFFF : 32'h8000_0001);
  endtask

  // Random bins in stretches, each with its own mix of idling, across frames.
  task automatic test_random_frames(input int unsigned count);
    int unsigned left;
    int unsigned run;
    left = count;
    while (left != 0) begin
      run = (left < 40) ? left : 40;
      idle_in   = $urandom_range(0, 1);
      stall_out = $urandom_range(0, 1);
      repeat (run)
        send_bin(pick_magnitude());
      left = left - run;
    end
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_CAP) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_saturation_edges();
    test_edges_with_stalls();
    test_random_frames(300);
    in_valid <= 1'b0;
    idle_in   = 1'b0;
    stall_out = 1'b0;
    // let the last accepted bin land in the expected queue
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/sfe_pkg.sv
rtl/spectrum_frame_encoder_top.sv
sim/tb.sv
